// ===== rtl/miller_rabin_primality_test_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Miller-Rabin unit assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MILLER_RABIN_PRIMALITY_TEST_UNIT_ASSERT_SVH
`define MILLER_RABIN_PRIMALITY_TEST_UNIT_ASSERT_SVH
`ifndef SYNTH
`define MR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define MR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/mrpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Miller-Rabin package
// Widths, base limits and controller states shared by the unit.
// ----------------------------------------------------------------------------
`default_nettype none
package mrpt_pkg;
	localparam int unsigned Width = 31;
	localparam int unsigned CntW = $clog2(Width + 1);
	localparam logic [Width-1:0] LimitOne = Width'(2047);
	localparam logic [Width-1:0] LimitTwo = Width'(1373653);
	localparam logic [Width-1:0] LimitThree = Width'(25326001);

	typedef logic [Width-1:0] word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPLIT,
		ST_BASE,
		ST_DIVCHK,
		ST_EXP_BIT,
		ST_EXP_MUL,
		ST_EXP_SQR,
		ST_CHECK,
		ST_SQR,
		ST_SQR_CHK,
		ST_DONE
	} state_t;

	// Witness base by index
	function automatic word_t witness(input logic [1:0] idx);
		word_t w;
		case (idx)
			2'd0: w = word_t'(2);
			2'd1: w = word_t'(3);
			2'd2: w = word_t'(5);
			default: w = word_t'(7);
		endcase
		return w;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/mrpt_mulmod.sv =====
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Computes a*b mod n one bit of b per cycle (MSB first, double and add).
// ----------------------------------------------------------------------------
`default_nettype none
`include "miller_rabin_primality_test_unit_assert.svh"
module mrpt_mulmod (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire mrpt_pkg::word_t a,
	input  wire mrpt_pkg::word_t b,
	input  wire mrpt_pkg::word_t n,
	output logic                 busy,
	output logic                 done,
	output mrpt_pkg::word_t      prod
);
	localparam int unsigned W = mrpt_pkg::Width;

	logic [W-1:0] acc_q, a_q, b_q, n_q;
	logic [mrpt_pkg::CntW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [W:0] dbl, dbl_r, add, add_r;

	// Double, reduce, conditionally add, reduce (values stay below n)
	always_comb begin
		dbl = {acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, n_q}) ? dbl - {1'b0, n_q} : dbl;
		add = dbl_r + (b_q[W-1] ? {1'b0, a_q} : '0);
		add_r = (add >= {1'b0, n_q}) ? add - {1'b0, n_q} : add;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= mrpt_pkg::CntW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == mrpt_pkg::CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			acc_q <= '0;
			a_q <= a;
			b_q <= b;
			n_q <= n;
		end else if (busy_q) begin
			acc_q <= add_r[W-1:0];
			b_q <= {b_q[W-2:0], 1'b0};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = acc_q;

	`MR_ASSERT_NEXT(a_done_after_busy, clk, arst_n, done_q, !busy_q)
	`MR_ASSERT_IMPL(a_cnt_busy, clk, arst_n, busy_q, cnt_q != '0)
	`MR_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy_q, busy_q)
endmodule
`default_nettype wire

// ===== rtl/miller_rabin_primality_test_unit.sv =====
// ----------------------------------------------------------------------------
// Miller-Rabin primality test unit
// Deterministic test of a 31-bit candidate with bases 2, 3, 5, 7.
// ----------------------------------------------------------------------------
// Channel | Ports                                   | Dir
// in      | candidate_valid, candidate_ready, candidate | in
// out     | is_prime_valid, is_prime_ready, is_prime    | out
//
// One candidate at a time. Each modular multiply runs a start, one serial
// step per bit of b, then done. Per base: a setup state, a serial remainder
// check of n by the base, then per exponent bit one decision state plus up
// to two multiplies; each later squaring is one multiply and a check state.
// d and s share at most 31 bits; trivial cases finish from the split state.
// Reset clears all control; the result beat waits in its register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "miller_rabin_primality_test_unit_assert.svh"
module miller_rabin_primality_test_unit (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 candidate_valid,
	output logic                      candidate_ready,
	input  wire logic [30:0]          candidate,
	output logic                      is_prime_valid,
	input  wire logic                 is_prime_ready,
	output logic                      is_prime
);
	localparam int unsigned W = mrpt_pkg::Width;

	mrpt_pkg::state_t state_q, state_d;
	mrpt_pkg::word_t n_q, d_q, exp_q, res_q, sq_q, rem_q, div_q;
	logic [mrpt_pkg::CntW-1:0] s_q, sql_q, bitc_q;
	logic [1:0] base_q, count_q;
	logic out_valid_q, out_bit_q, verd_q;

	logic mm_start, mm_busy, mm_done;
	mrpt_pkg::word_t mm_a, mm_b, mm_prod;

	mrpt_mulmod u_mulmod (
		.clk(clk), .arst_n(arst_n), .start(mm_start), .a(mm_a), .b(mm_b),
		.n(n_q), .busy(mm_busy), .done(mm_done), .prod(mm_prod)
	);

	logic is_one, is_nm1;
	logic [W:0] rem_sh;
	assign is_one = (res_q == mrpt_pkg::word_t'(1));
	assign is_nm1 = (res_q == n_q - 1'b1);
	// Serial remainder step: shift in next bit of n, then subtract base if it fits
	assign rem_sh = {rem_q, div_q[W-1]};

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mrpt_pkg::ST_IDLE: if (candidate_valid && candidate_ready) state_d = mrpt_pkg::ST_SPLIT;
			mrpt_pkg::ST_SPLIT: begin
				if (n_q < mrpt_pkg::word_t'(4) || !n_q[0]) state_d = mrpt_pkg::ST_DONE;
				else if (d_q[0]) state_d = mrpt_pkg::ST_BASE;
			end
			mrpt_pkg::ST_BASE: state_d = mrpt_pkg::ST_DIVCHK;
			mrpt_pkg::ST_DIVCHK: begin
				if (bitc_q == '0) begin
					if (rem_q == '0) state_d = mrpt_pkg::ST_DONE;
					else state_d = mrpt_pkg::ST_EXP_BIT;
				end
			end
			mrpt_pkg::ST_EXP_BIT: begin
				if (exp_q == '0) state_d = mrpt_pkg::ST_CHECK;
				else if (exp_q[0]) state_d = mrpt_pkg::ST_EXP_MUL;
				else state_d = mrpt_pkg::ST_EXP_SQR;
			end
			mrpt_pkg::ST_EXP_MUL: if (mm_done) state_d = mrpt_pkg::ST_EXP_SQR;
			mrpt_pkg::ST_EXP_SQR: if (mm_done) state_d = mrpt_pkg::ST_EXP_BIT;
			mrpt_pkg::ST_CHECK: begin
				if (is_one || is_nm1) state_d = (base_q == count_q) ? mrpt_pkg::ST_DONE
					: mrpt_pkg::ST_BASE;
				else if (sql_q == '0) state_d = mrpt_pkg::ST_DONE;
				else state_d = mrpt_pkg::ST_SQR;
			end
			mrpt_pkg::ST_SQR: if (mm_done) state_d = mrpt_pkg::ST_SQR_CHK;
			mrpt_pkg::ST_SQR_CHK: begin
				// sql_q still holds the count before this squaring
				if (is_one) state_d = mrpt_pkg::ST_DONE;
				else if (is_nm1) state_d = (base_q == count_q) ? mrpt_pkg::ST_DONE
					: mrpt_pkg::ST_BASE;
				else if (sql_q == mrpt_pkg::CntW'(1)) state_d = mrpt_pkg::ST_DONE;
				else state_d = mrpt_pkg::ST_SQR;
			end
			mrpt_pkg::ST_DONE: if (!out_valid_q || is_prime_ready) state_d = mrpt_pkg::ST_IDLE;
			default: state_d = mrpt_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		mm_start = 1'b0;
		mm_a = res_q;
		mm_b = sq_q;
		case (state_q)
			mrpt_pkg::ST_EXP_MUL: begin
				mm_start = !mm_busy && !mm_done;
			end
			mrpt_pkg::ST_EXP_SQR: begin
				mm_start = !mm_busy && !mm_done;
				mm_a = sq_q;
			end
			mrpt_pkg::ST_SQR: begin
				mm_start = !mm_busy && !mm_done;
				mm_b = res_q;
			end
			default: mm_start = 1'b0;
		endcase
	end

	assign candidate_ready = (state_q == mrpt_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrpt_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mrpt_pkg::ST_DONE && state_d == mrpt_pkg::ST_IDLE)
				out_valid_q <= 1'b1;
			else if (is_prime_valid && is_prime_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			mrpt_pkg::ST_IDLE: begin
				n_q <= candidate;
				d_q <= candidate - 1'b1;
				s_q <= '0;
				base_q <= '0;
				verd_q <= (candidate == 31'd2) || (candidate == 31'd3);
			end
			mrpt_pkg::ST_SPLIT: begin
				if (!d_q[0]) begin
					d_q <= d_q >> 1;
					s_q <= s_q + 1'b1;
				end
				if (n_q < mrpt_pkg::LimitOne) count_q <= 2'd0;
				else if (n_q < mrpt_pkg::LimitTwo) count_q <= 2'd1;
				else if (n_q < mrpt_pkg::LimitThree) count_q <= 2'd2;
				else count_q <= 2'd3;
			end
			mrpt_pkg::ST_BASE: begin
				rem_q <= '0;
				div_q <= n_q;
				bitc_q <= mrpt_pkg::CntW'(W);
				sq_q <= mrpt_pkg::witness(base_q);
				res_q <= mrpt_pkg::word_t'(1);
				exp_q <= d_q;
				sql_q <= s_q - 1'b1;
				verd_q <= 1'b0;
			end
			mrpt_pkg::ST_DIVCHK: begin
				if (bitc_q != '0) begin
					rem_q <= (rem_sh >= {1'b0, sq_q}) ? W'(rem_sh - {1'b0, sq_q})
						: rem_sh[W-1:0];
					div_q <= {div_q[W-2:0], 1'b0};
					bitc_q <= bitc_q - 1'b1;
				end
			end
			mrpt_pkg::ST_EXP_MUL: if (mm_done) res_q <= mm_prod;
			mrpt_pkg::ST_EXP_SQR: if (mm_done) begin
				sq_q <= mm_prod;
				exp_q <= exp_q >> 1;
			end
			mrpt_pkg::ST_CHECK: begin
				if (is_one || is_nm1) begin
					base_q <= base_q + 1'b1;
					verd_q <= (base_q == count_q);
				end
			end
			mrpt_pkg::ST_SQR: if (mm_done) res_q <= mm_prod;
			mrpt_pkg::ST_SQR_CHK: begin
				sql_q <= sql_q - 1'b1;
				if (!is_one && is_nm1) begin
					base_q <= base_q + 1'b1;
					verd_q <= (base_q == count_q);
				end
			end
			// Result register loads only as the beat is launched
			mrpt_pkg::ST_DONE: if (state_d == mrpt_pkg::ST_IDLE) out_bit_q <= verd_q;
			default: begin end
		endcase
	end

	assign is_prime_valid = out_valid_q;
	assign is_prime = out_bit_q;

	`MR_ASSERT_IMPL(a_ready_idle, clk, arst_n, candidate_ready, state_q == mrpt_pkg::ST_IDLE)
	`MR_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n,
		candidate_valid && candidate_ready, state_q == mrpt_pkg::ST_SPLIT)
	`MR_ASSERT_IMPL(a_mul_only_in_mul, clk, arst_n, mm_start,
		state_q == mrpt_pkg::ST_EXP_MUL || state_q == mrpt_pkg::ST_EXP_SQR ||
		state_q == mrpt_pkg::ST_SQR)
endmodule
`default_nettype wire

// ===== test/tb_miller_rabin_primality_test_unit.sv =====
// ----------------------------------------------------------------------------
// Miller-Rabin unit testbench
// Drives candidates over the input channel and checks each is_prime beat in
// order against a typed verdict or local deterministic Miller-Rabin predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_miller_rabin_primality_test_unit;

	localparam int WatchLimit = 200000;

	logic       clk;
	logic       arst_n;
	logic       candidate_valid;
	logic       candidate_ready;
	logic [30:0] candidate;
	logic       is_prime_valid;
	logic       is_prime_ready;
	logic       is_prime;

	// directed row: candidate, typed expectation, whether it is typed
	typedef struct {
		logic [30:0] value;
		logic        verdict;
		bit          typed;
	} row_t;

	bit   prime_q[$];
	int   err_cnt;
	int   beats_in;
	int   beats_out;
	int   idle_cnt;
	int   send_idle;
	int   recv_idle;
	bit   timed_out;

	miller_rabin_primality_test_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.candidate_valid(candidate_valid),
		.candidate_ready(candidate_ready),
		.candidate      (candidate),
		.is_prime_valid (is_prime_valid),
		.is_prime_ready (is_prime_ready),
		.is_prime       (is_prime)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// modular multiply on 64-bit products
	function automatic logic [31:0] mod_mul(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] n);
		logic [63:0] p;
		p = {32'd0, x} * {32'd0, y};
		return 32'(p % {32'd0, n});
	endfunction

	// one witness round: a^d, then up to s-1 squarings
	function automatic bit witness_ok(input logic [31:0] a, input logic [31:0] d,
			input int s, input logic [31:0] n);
		logic [31:0] r;
		logic [31:0] sq;
		logic [31:0] e;
		int          k;
		r = 1;
		sq = a % n;
		e = d;
		while (e != 0) begin
			if (e[0])
				r = mod_mul(r, sq, n);
			sq = mod_mul(sq, sq, n);
			e = e >> 1;
		end
		if (r == 1 || r == n - 1)
			return 1'b1;
		k = (s - 1) & 31;
		while (k != 0) begin
			r = mod_mul(r, r, n);
			if (r == 1)
				return 1'b0;
			if (r == n - 1)
				return 1'b1;
			k--;
		end
		return 1'b0;
	endfunction

	// deterministic primality verdict for a 31-bit candidate
	function automatic bit prime_verdict(input logic [30:0] c);
		logic [31:0] n;
		logic [31:0] d;
		logic [31:0] a;
		int          s;
		int          bases;
		n = {1'b0, c};
		if (n < 2)
			return 1'b0;
		if (n == 2 || n == 3)
			return 1'b1;
		if (!n[0])
			return 1'b0;
		d = n - 1;
		s = 0;
		while (!d[0]) begin
			d = d >> 1;
			s++;
		end
		if (c < mrpt_pkg::LimitOne)
			bases = 1;
		else if (c < mrpt_pkg::LimitTwo)
			bases = 2;
		else if (c < mrpt_pkg::LimitThree)
			bases = 3;
		else
			bases = 4;
		for (int i = 0; i < bases; i++) begin
			a = 32'(mrpt_pkg::witness(2'(i)));
			if (n % a == 0)
				return 1'b0;
			if (!witness_ok(a, d, s, n))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// send one candidate beat and queue its expected verdict; valid stays
	// high after the beat until the next call idles or replaces it
	task automatic send_candidate(input logic [30:0] c, input logic verdict, input bit typed);
		if (send_idle != 0 && $urandom_range(99) < send_idle) begin
			candidate_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle)
				@(posedge clk);
		end
		candidate_valid <= 1'b1;
		candidate <= c;
		if (typed)
			prime_q.push_back(verdict);
		else
			prime_q.push_back(prime_verdict(c));
		@(posedge clk);
		while (!candidate_ready)
			@(posedge clk);
		beats_in++;
	endtask

	// random candidate: mostly odd, mostly smaller sizes to bound run time
	function automatic logic [30:0] rand_candidate();
		logic [30:0] c;
		int          pick;
		pick = $urandom_range(9);
		case (pick)
			0, 1, 2: c = 31'($urandom_range(1, 2046));
			3, 4: c = 31'($urandom_range(2047, 1373652));
			5: c = 31'($urandom_range(1373653, 25326000));
			6: c = 31'($urandom);
			default: c = 31'($urandom_range(3, 200000));
		endcase
		if (pick != 6 && $urandom_range(9) != 0)
			c[0] = 1'b1;
		return c;
	endfunction

	// receiver stalls and result check
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_prime_ready <= 1'b0;
		end else begin
			is_prime_ready <= !(recv_idle != 0 && $urandom_range(99) < recv_idle);
			if (is_prime_valid && is_prime_ready) begin
				beats_out++;
				if (prime_q.size() == 0) begin
					$display("%0t: unexpected is_prime beat, actual %0b", $time, is_prime);
					err_cnt++;
				end else begin
					if (prime_q[0] !== is_prime) begin
						$display("%0t: is_prime mismatch, expected %0b actual %0b",
							$time, prime_q[0], is_prime);
						err_cnt++;
					end
					void'(prime_q.pop_front());
				end
			end
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if ((candidate_valid && candidate_ready) || (is_prime_valid && is_prime_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WatchLimit && !timed_out) begin
			timed_out = 1'b1;
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		int   phase;
		logic [30:0] tv;
		err_cnt = 0;
		beats_in = 0;
		beats_out = 0;
		send_idle = 14;
		recv_idle = 48;
		arst_n = 1'b0;
		candidate_valid = 1'b0;
		candidate = '0;
		rows = '{
			'{31'd0, 1'b0, 1'b1},
			'{31'd1, 1'b0, 1'b1},
			'{31'd2, 1'b1, 1'b1},
			'{31'd3, 1'b1, 1'b1},
			'{31'd4, 1'b0, 1'b1},
			'{31'd5, 1'b0, 1'b0},
			'{31'd9, 1'b0, 1'b0},
			'{31'd2046, 1'b0, 1'b1},
			'{31'd2047, 1'b0, 1'b0},
			'{31'd2053, 1'b0, 1'b0},
			'{31'd1373653, 1'b0, 1'b0},
			'{31'd1373651, 1'b0, 1'b0},
			'{31'd25326001, 1'b0, 1'b0},
			'{31'd25326023, 1'b0, 1'b0},
			'{31'd2147483629, 1'b0, 1'b0},
			'{31'd2147483647, 1'b0, 1'b0},
			'{31'd2147483646, 1'b0, 1'b1},
			'{31'd1431655765, 1'b0, 1'b0},
			'{31'd715827883, 1'b0, 1'b0},
			'{31'd49, 1'b0, 1'b0},
			'{31'd561, 1'b0, 1'b0},
			'{31'd7919, 1'b0, 1'b0}
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (rows[i])
			send_candidate(rows[i].value, rows[i].verdict, rows[i].typed);
		candidate_valid <= 1'b0;

		// hold off until every expected verdict has come back
		while (prime_q.size() != 0)
			@(posedge clk);

		// random part over three idling phases
		for (phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 14 : (phase == 1) ? 48 : 0;
			recv_idle = (phase == 0) ? 48 : (phase == 1) ? 14 : 0;
			for (int j = 0; j < 26; j++) begin
				tv = rand_candidate();
				send_candidate(tv, 1'b0, 1'b0);
			end
		end
		candidate_valid <= 1'b0;

		while (prime_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("Sent %0d candidates, checked %0d verdicts across trivial, one- to four-base",
			beats_in, beats_out);
		$display("ranges and three idling phases; %0d mismatches", err_cnt);
		if (err_cnt == 0 && prime_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/mrpt_pkg.sv
rtl/mrpt_mulmod.sv
rtl/miller_rabin_primality_test_unit.sv
test/tb_miller_rabin_primality_test_unit.sv
